>>> hdl/lfu_pkg.sv
`default_nettype none
package lfu_pkg;

    localparam int LFU_ENTRIES = 16;

    localparam int KEY_W = 32;
    localparam int DATA_W = 32;
    localparam int CNT_W = 32;

    localparam int CAP_W = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_SET = 1'b1;

    localparam logic REG_CAPACITY = 1'b0;

    localparam logic [DATA_W-1:0] MISS_VALUE = '1;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] data;
        logic [CNT_W-1:0]  cnt;
    } t_ent;

    typedef struct packed {
        logic key_en;
        logic data_en;
        logic cnt_en;
        t_ent ent;
    } t_ent_wr;

endpackage
`default_nettype wire

>>> hdl/lfu_store.sv
`default_nettype none
module lfu_store #(
    parameter int ENTRIES = lfu_pkg::LFU_ENTRIES,
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
    localparam int RW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  wire                  i_clk,
    input  wire  [IW-1:0]        i_rd_addr,
    output lfu_pkg::t_ent        o_rd,
    output logic [RW-1:0]        o_rd_rank,
    input  wire lfu_pkg::t_ent_wr i_wr,
    input  wire  [IW-1:0]        i_wr_addr,
    input  wire                  i_rk_we,
    input  wire  [IW-1:0]        i_rk_waddr,
    input  wire  [RW-1:0]        i_rk_wdata
);
    import lfu_pkg::*;

    logic [KEY_W-1:0]  mem_key  [ENTRIES];
    logic [DATA_W-1:0] mem_data [ENTRIES];
    logic [CNT_W-1:0]  mem_cnt  [ENTRIES];
    logic [RW-1:0]     mem_rank [ENTRIES];

    always_ff @(posedge i_clk) begin
        if (i_wr.key_en) begin
            mem_key[i_wr_addr] <= i_wr.ent.key;
        end
        if (i_wr.data_en) begin
            mem_data[i_wr_addr] <= i_wr.ent.data;
        end
        if (i_wr.cnt_en) begin
            mem_cnt[i_wr_addr] <= i_wr.ent.cnt;
        end
        o_rd.key  <= mem_key[i_rd_addr];
        o_rd.data <= mem_data[i_rd_addr];
        o_rd.cnt  <= mem_cnt[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_rk_we) begin
            mem_rank[i_rk_waddr] <= i_rk_wdata;
        end
        o_rd_rank <= mem_rank[i_rd_addr];
    end

endmodule
`default_nettype wire

>>> hdl/lfu_cache_policy.sv
// One item at a time: a new item is taken only once the last one's result
//   has been handed to the output register. One pass of the entry memory
//   finds match, free slot and victim; a second pass rewrites the recency
//   ranks, skipped for a get miss or a set that does nothing.
// Reset: synchronous, active low; clears valid bits, occupancy and the
//   handshake state, capacity returns to 16. No clearing pass is needed.
`default_nettype none
module lfu_cache_policy #(
    parameter int ENTRIES = lfu_pkg::LFU_ENTRIES
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // slave side
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [63:0] i_s_axis_tdata,   // [31:0] key, [63:32] value
    input  wire  [0:0]  i_s_axis_tuser,   // [0] command
    // master side
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [31:0] read_value
    output logic [0:0]  o_m_axis_tuser,   // [0] hit
    // configuration
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lfu_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OW = $clog2(ENTRIES + 1);
    localparam int CW = (OW > CAP_W) ? OW : CAP_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_DRAIN  = 3'd2;
    localparam logic [2:0] ST_ACT    = 3'd3;
    localparam logic [2:0] ST_RANK   = 3'd4;
    localparam logic [2:0] ST_RDRAIN = 3'd5;
    localparam logic [2:0] ST_FIN    = 3'd6;

    logic [2:0]        r_state, n_state;
    logic [IW-1:0]     r_ptr;
    logic              r_ph;
    logic [IW-1:0]     r_ph_idx;

    logic              r_cmd;
    logic [KEY_W-1:0]  r_key;
    logic [DATA_W-1:0] r_val;

    logic              r_found;
    logic [IW-1:0]     r_slot;
    logic [DATA_W-1:0] r_slot_data;
    logic [CNT_W-1:0]  r_slot_cnt;
    logic [RW-1:0]     r_slot_rank;
    logic              r_have_free;
    logic [IW-1:0]     r_free;
    logic              r_have_v;
    logic [IW-1:0]     r_v;
    logic [CNT_W-1:0]  r_v_cnt;
    logic [RW-1:0]     r_v_rank;

    logic [ENTRIES-1:0] r_valid;
    logic [OW-1:0]      r_occ;
    logic [CAP_W-1:0]   r_cap;

    logic              r_rec_all;
    logic [IW-1:0]     r_rec_slot;
    logic [RW-1:0]     r_rec_old;

    logic              r_res_hit;
    logic [DATA_W-1:0] r_res_data;
    logic              r_m_valid;
    logic              r_m_hit;
    logic [DATA_W-1:0] r_m_data;

    t_ent              rd;
    logic [RW-1:0]     rd_rank;
    t_ent_wr           wr;
    logic [IW-1:0]     wr_addr;
    logic              rk_we;
    logic [RW-1:0]     rk_wdata;

    logic              s_acc;
    logic              scan_proc;
    logic              rank_proc;
    logic              rd_valid;
    logic              is_match;
    logic              better_v;

    logic [CW-1:0]     cap_x;
    logic [CW-1:0]     occ_x;
    logic [CW-1:0]     cap_eff;
    logic              do_evict;
    logic              do_insert;
    logic              do_recent;
    logic [CNT_W-1:0]  cnt_inc;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_CAPACITY) ? {{(32 - CAP_W){1'b0}}, r_cap} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_CAPACITY) begin
            r_cap <= pwdata[CAP_W-1:0];
        end
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign s_acc = i_s_axis_tvalid && o_s_axis_tready;

    assign o_m_axis_tvalid   = r_m_valid;
    assign o_m_axis_tdata    = r_m_data;
    assign o_m_axis_tuser[0] = r_m_hit;

    lfu_store #(
        .ENTRIES(ENTRIES)
    ) u_store (
        .i_clk      (i_clk),
        .i_rd_addr  (r_ptr),
        .o_rd       (rd),
        .o_rd_rank  (rd_rank),
        .i_wr       (wr),
        .i_wr_addr  (wr_addr),
        .i_rk_we    (rk_we),
        .i_rk_waddr (r_ph_idx),
        .i_rk_wdata (rk_wdata)
    );

    // scan pass: compare the entry read last cycle against the trackers
    assign scan_proc = r_ph && (r_state inside {ST_SCAN, ST_DRAIN});
    assign rank_proc = r_ph && (r_state inside {ST_RANK, ST_RDRAIN});
    assign rd_valid  = r_valid[r_ph_idx];
    assign is_match  = rd_valid && (rd.key == r_key);
    assign better_v  = rd_valid && (!r_have_v || rd.cnt < r_v_cnt ||
                       (rd.cnt == r_v_cnt && rd_rank > r_v_rank));

    // decision after the scan
    assign cap_x   = CW'(r_cap);
    assign occ_x   = CW'(r_occ);
    assign cap_eff = (cap_x > CW'(ENTRIES)) ? CW'(ENTRIES) : cap_x;
    assign do_evict  = (r_cmd == CMD_SET) && !r_found && (occ_x != '0) && (occ_x == cap_eff);
    assign do_insert = (r_cmd == CMD_SET) && !r_found && (occ_x < cap_eff) && r_have_free;
    assign do_recent = r_found || do_evict || do_insert;
    assign cnt_inc   = (r_slot_cnt == CNT_MAX) ? r_slot_cnt : r_slot_cnt + 1'b1;

    always_comb begin
        wr = '0;
        wr_addr = r_slot;
        wr.ent.key  = r_key;
        wr.ent.data = r_val;
        wr.ent.cnt  = CNT_W'(1);
        if (r_state == ST_ACT) begin
            if (r_found) begin
                wr.cnt_en  = 1'b1;
                wr.ent.cnt = cnt_inc;
                wr.data_en = (r_cmd == CMD_SET);
            end else if (do_evict) begin
                wr_addr    = r_v;
                wr.key_en  = 1'b1;
                wr.data_en = 1'b1;
                wr.cnt_en  = 1'b1;
            end else if (do_insert) begin
                wr_addr    = r_free;
                wr.key_en  = 1'b1;
                wr.data_en = 1'b1;
                wr.cnt_en  = 1'b1;
            end
        end
    end

    // rank pass: the touched slot becomes rank 0, more recent ones move back
    always_comb begin
        rk_we    = 1'b0;
        rk_wdata = rd_rank + 1'b1;
        if (rank_proc) begin
            if (r_ph_idx == r_rec_slot) begin
                rk_we    = 1'b1;
                rk_wdata = '0;
            end else if (rd_valid && (r_rec_all || rd_rank < r_rec_old)) begin
                rk_we = 1'b1;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (s_acc) n_state = ST_SCAN;
            ST_SCAN:   if (r_ptr == LAST_IDX) n_state = ST_DRAIN;
            ST_DRAIN:  n_state = ST_ACT;
            ST_ACT:    n_state = do_recent ? ST_RANK : ST_FIN;
            ST_RANK:   if (r_ptr == LAST_IDX) n_state = ST_RDRAIN;
            ST_RDRAIN: n_state = ST_FIN;
            ST_FIN:    if (!r_m_valid || i_m_axis_tready) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_ph      <= 1'b0;
            r_valid   <= '0;
            r_occ     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ph    <= (r_state inside {ST_SCAN, ST_RANK});
            if (r_state == ST_ACT && do_insert) begin
                r_valid[r_free] <= 1'b1;
                r_occ <= r_occ + 1'b1;
            end
            if (r_state == ST_FIN && (!r_m_valid || i_m_axis_tready)) begin
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ph_idx <= r_ptr;
        if (r_state inside {ST_SCAN, ST_RANK}) begin
            r_ptr <= r_ptr + 1'b1;
        end else begin
            r_ptr <= '0;
        end

        if (s_acc) begin
            r_cmd       <= i_s_axis_tuser[0];
            r_key       <= i_s_axis_tdata[31:0];
            r_val       <= i_s_axis_tdata[63:32];
            r_found     <= 1'b0;
            r_have_free <= 1'b0;
            r_have_v    <= 1'b0;
        end

        if (scan_proc) begin
            if (is_match && !r_found) begin
                r_found     <= 1'b1;
                r_slot      <= r_ph_idx;
                r_slot_data <= rd.data;
                r_slot_cnt  <= rd.cnt;
                r_slot_rank <= rd_rank;
            end
            if (!rd_valid && !r_have_free) begin
                r_have_free <= 1'b1;
                r_free      <= r_ph_idx;
            end
            if (better_v) begin
                r_have_v <= 1'b1;
                r_v      <= r_ph_idx;
                r_v_cnt  <= rd.cnt;
                r_v_rank <= rd_rank;
            end
        end

        if (r_state == ST_ACT) begin
            r_res_hit <= r_found;
            if (r_cmd == CMD_GET) begin
                r_res_data <= r_found ? r_slot_data : MISS_VALUE;
            end else begin
                r_res_data <= '0;
            end
            if (r_found) begin
                r_rec_slot <= r_slot;
                r_rec_old  <= r_slot_rank;
                r_rec_all  <= 1'b0;
            end else if (do_evict) begin
                r_rec_slot <= r_v;
                r_rec_old  <= r_v_rank;
                r_rec_all  <= 1'b0;
            end else begin
                r_rec_slot <= r_free;
                r_rec_old  <= '0;
                r_rec_all  <= 1'b1;
            end
        end

        if (r_state == ST_FIN && (!r_m_valid || i_m_axis_tready)) begin
            r_m_hit  <= r_res_hit;
            r_m_data <= r_res_data;
        end
    end

endmodule
`default_nettype wire

>>> tb/lfu_cache_policy_checker.sv
`timescale 1ns / 1ps
module lfu_cache_policy_checker (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    input  wire         i_s_tready,
    input  wire  [63:0] i_s_tdata,    // [31:0] key, [63:32] value
    input  wire  [0:0]  i_s_tuser,    // [0] command
    input  wire         i_m_tvalid,
    input  wire         i_m_tready,
    input  wire  [31:0] i_m_tdata,    // [31:0] read_value
    input  wire  [0:0]  i_m_tuser,    // [0] hit
    input  wire         i_psel,
    input  wire         i_penable,
    input  wire         i_pwrite,
    input  wire  [2:0]  i_paddr,
    input  wire  [31:0] i_pwdata,
    input  wire  [31:0] i_prdata,
    input  wire         i_pready,
    output int          o_pending,
    output int          o_fail_count
);
    import lfu_pkg::*;

    localparam int SLOTS = LFU_ENTRIES;

    typedef struct packed {
        logic              hit;
        logic [DATA_W-1:0] value;
    } t_reply;

    logic              slot_valid [SLOTS];
    logic [KEY_W-1:0]  slot_key   [SLOTS];
    logic [DATA_W-1:0] slot_data  [SLOTS];
    logic [CNT_W-1:0]  slot_uses  [SLOTS];
    int unsigned       slot_age   [SLOTS];    // 0 is the most recent
    int unsigned       held;
    logic [CAP_W-1:0]  cap_reg;

    t_reply reply_q[$];
    int     fails = 0;

    assign o_fail_count = fails;

    // Move slot s to the front; valid slots newer than old_age fall back one.
    task automatic promote(input int s, input int unsigned old_age);
        for (int i = 0; i < SLOTS; i++) begin
            if (i != s && slot_valid[i] && slot_age[i] < old_age)
                slot_age[i]++;
        end
        slot_age[s] = 0;
    endtask

    task automatic bump_use(input int s);
        if (slot_uses[s] != CNT_MAX)
            slot_uses[s]++;
        promote(s, slot_age[s]);
    endtask

    task automatic serve_request(input logic cmd, input logic [KEY_W-1:0] key,
                                 input logic [DATA_W-1:0] data, output t_reply r);
        int unsigned limit;
        int          found;
        int          pick;
        limit = (cap_reg > SLOTS) ? SLOTS : cap_reg;
        found = -1;
        for (int i = 0; i < SLOTS; i++) begin
            if (found < 0 && slot_valid[i] && slot_key[i] == key)
                found = i;
        end
        r.hit = (found >= 0);
        r.value = '0;
        if (cmd == CMD_GET) begin
            if (found >= 0) begin
                bump_use(found);
                r.value = slot_data[found];
            end else begin
                r.value = MISS_VALUE;
            end
        end else if (found >= 0) begin
            slot_data[found] = data;
            bump_use(found);
        end else if (held > 0 && held == limit) begin
            // evict the fewest uses, oldest among equals
            pick = -1;
            for (int i = 0; i < SLOTS; i++) begin
                if (slot_valid[i] && (pick < 0 || slot_uses[i] < slot_uses[pick] ||
                    (slot_uses[i] == slot_uses[pick] && slot_age[i] > slot_age[pick])))
                    pick = i;
            end
            slot_key[pick] = key;
            slot_data[pick] = data;
            slot_uses[pick] = 1;
            promote(pick, slot_age[pick]);
        end else if (held < limit) begin
            pick = -1;
            for (int i = 0; i < SLOTS; i++) begin
                if (pick < 0 && !slot_valid[i])
                    pick = i;
            end
            if (pick >= 0) begin
                promote(pick, 32'hFFFF_FFFF);
                slot_valid[pick] = 1'b1;
                slot_key[pick] = key;
                slot_data[pick] = data;
                slot_uses[pick] = 1;
                held++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_reply want;
        t_reply got;
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++)
                slot_valid[i] = 1'b0;
            held = 0;
            cap_reg = CAP_RESET;
            reply_q.delete();
        end else begin
            if (i_psel && i_penable && i_pready && i_paddr[2] == REG_CAPACITY) begin
                if (i_pwrite) begin
                    cap_reg = i_pwdata[CAP_W-1:0];
                end else if (i_prdata !== 32'(cap_reg)) begin
                    $error("capacity: expected %0d, actual %0d", cap_reg, i_prdata);
                    fails++;
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                serve_request(i_s_tuser[0], i_s_tdata[31:0], i_s_tdata[63:32], want);
                reply_q.insert(reply_q.size(), want);
            end
            if (i_m_tvalid && i_m_tready) begin
                got.hit = i_m_tuser[0];
                got.value = i_m_tdata;
                if (reply_q.size() == 0) begin
                    $error("unexpected item: hit %0d, read_value %h", got.hit, got.value);
                    fails++;
                end else begin
                    want = reply_q.pop_front();
                    if (got.hit !== want.hit) begin
                        $error("hit: expected %0d, actual %0d", want.hit, got.hit);
                        fails++;
                    end
                    if (got.value !== want.value) begin
                        $error("read_value: expected %h, actual %h", want.value, got.value);
                        fails++;
                    end
                end
            end
        end
        o_pending <= reply_q.size();
    end

endmodule

>>> tb/lfu_cache_policy_tb.sv
`timescale 1ns / 1ps
module lfu_cache_policy_tb;
    import lfu_pkg::*;

    localparam int CLK_HALF = 6;
    localparam int SETTLE_CYCLES = 2 * LFU_ENTRIES + 8;
    localparam int POOL = 24;
    localparam int PHASE_ITEMS = 112;

    localparam logic [2:0] ADDR_CAPACITY = {REG_CAPACITY, 2'b00};
    localparam logic [2:0] ADDR_SPARE = 3'd4;

    localparam logic [KEY_W-1:0] KEY_MIN = 32'h8000_0000;
    localparam logic [KEY_W-1:0] KEY_MAX = 32'h7FFF_FFFF;
    localparam logic [KEY_W-1:0] KEY_ZERO = 32'h0000_0000;
    localparam logic [KEY_W-1:0] KEY_ONES = 32'hFFFF_FFFF;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    logic        calm = 1'b0;
    int          stall_left = 0;
    int          n_pending;
    int          n_fail;

    logic [KEY_W-1:0] key_pool[POOL];

    lfu_cache_policy dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    lfu_cache_policy_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .o_pending    (n_pending),
        .o_fail_count (n_fail)
    );

    always begin
        #(CLK_HALF) clk = 1'b1;
        #(CLK_HALF) clk = 1'b0;
    end

    // Receiver: stall in random bursts, never once the run has gone calm.
    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready <= (stall_left == 1);
        end else if (!calm && $urandom_range(0, 4) == 0) begin
            stall_left <= $urandom_range(1, 12);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_req(input logic cmd, input logic [KEY_W-1:0] key,
                            input logic [DATA_W-1:0] data);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {data, key};
        s_tuser <= cmd;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // Hold until every reply is back and the block has gone quiet.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (n_pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_access(input logic wr, input logic [2:0] addr,
                              input logic [31:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] cap);
        apb_access(1'b1, ADDR_CAPACITY, 32'(cap));
        apb_access(1'b0, ADDR_CAPACITY, '0);
    endtask

    task automatic run_phase(input logic [CAP_W-1:0] cap, input int n_items);
        int unsigned span;
        logic        cmd;
        logic [KEY_W-1:0] key;
        set_capacity(cap);
        span = ((cap > LFU_ENTRIES) ? LFU_ENTRIES : cap) + 3;
        // refresh part of the pool so new keys keep arriving
        for (int k = 0; k < 3; k++)
            key_pool[$urandom_range(4, POOL - 1)] = $urandom;
        for (int n = 0; n < n_items; n++) begin
            cmd = $urandom_range(0, 1) ? CMD_SET : CMD_GET;
            if ($urandom_range(0, 9) < 8)
                key = key_pool[$urandom_range(0, span - 1)];
            else
                key = $urandom;
            send_req(cmd, key, $urandom);
        end
        drain();
    endtask

    initial begin
        #(6_000_000);
        $display("Mismatches found");
        $finish;
    end

    initial begin
        key_pool[0] = KEY_MIN;
        key_pool[1] = KEY_MAX;
        key_pool[2] = KEY_ZERO;
        key_pool[3] = KEY_ONES;
        for (int k = 4; k < POOL; k++)
            key_pool[k] = $urandom;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // empty store after reset
        send_req(CMD_GET, KEY_ZERO, KEY_ONES);
        drain();

        // capacity zero: a set on a new key does nothing
        set_capacity(5'd0);
        send_req(CMD_SET, KEY_MIN, KEY_MAX);
        send_req(CMD_GET, KEY_MIN, KEY_ZERO);
        drain();

        set_capacity(5'd1);
        send_req(CMD_SET, KEY_MAX, KEY_MIN);
        send_req(CMD_GET, KEY_MAX, KEY_ZERO);
        send_req(CMD_SET, KEY_MIN, KEY_MAX);
        send_req(CMD_GET, KEY_MAX, KEY_ZERO);
        send_req(CMD_GET, KEY_MIN, KEY_ZERO);
        send_req(CMD_SET, KEY_MIN, KEY_ONES);
        send_req(CMD_GET, KEY_MIN, KEY_ZERO);
        drain();

        // fewest uses goes first
        set_capacity(5'd2);
        send_req(CMD_SET, KEY_ZERO, KEY_ZERO);
        send_req(CMD_GET, KEY_MIN, KEY_ZERO);
        send_req(CMD_SET, KEY_ONES, 32'h1234_5678);
        send_req(CMD_GET, KEY_ZERO, KEY_ZERO);
        send_req(CMD_GET, KEY_ONES, KEY_ZERO);
        drain();

        // equal uses: the least recent goes first
        set_capacity(5'd4);
        apb_access(1'b1, ADDR_SPARE, 32'd1);
        send_req(CMD_SET, 32'h0000_0001, 32'h0000_0011);
        send_req(CMD_SET, 32'h0000_0002, 32'h0000_0022);
        send_req(CMD_SET, 32'h0000_0003, 32'h0000_0033);
        send_req(CMD_SET, 32'h0000_0004, 32'h0000_0044);
        send_req(CMD_GET, 32'h0000_0001, KEY_ZERO);
        send_req(CMD_GET, 32'h0000_0002, KEY_ZERO);
        send_req(CMD_GET, 32'h0000_0001, KEY_ZERO);
        send_req(CMD_SET, 32'h0000_0005, 32'h0000_0055);
        send_req(CMD_GET, 32'h0000_0003, KEY_ZERO);
        send_req(CMD_GET, 32'h0000_0004, KEY_ZERO);
        drain();

        run_phase(5'd5, PHASE_ITEMS);
        run_phase(5'd8, PHASE_ITEMS);
        run_phase(5'd12, PHASE_ITEMS);
        run_phase(5'd31, PHASE_ITEMS);
        // store is full now; a smaller capacity leaves it over the limit
        run_phase(5'd3, PHASE_ITEMS);
        run_phase(5'd16, PHASE_ITEMS);
        calm <= 1'b1;
        run_phase(5'd16, PHASE_ITEMS);

        if (n_fail == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
